// ----- sv/scurve_pkg.sv -----
`timescale 1ns / 1ps

package scurve_pkg;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_TARGET = 2'd1,
        ACT_PRESET = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } phase_t;

    typedef enum logic {
        REG_ACCEL_DISTANCE = 1'b0,
        REG_CRUISE_STEP    = 1'b1
    } cfg_reg_t;

    localparam int ROM_DEPTH  = 32;
    localparam int ROM_WIDTH  = 15;
    localparam int DIST_WIDTH = 21;

    localparam logic [DIST_WIDTH-1:0] ACCEL_DISTANCE_RESET = 21'd86937;
    localparam logic [DIST_WIDTH-1:0] CRUISE_STEP_RESET    = 21'd16471;

    // Sigmoid velocity steps, Q11.20 radians per tick
    localparam logic [ROM_WIDTH-1:0] ACCEL_ROM [ROM_DEPTH] = '{
        15'd1098,  15'd1735,  15'd2678,  15'd3994,  15'd5690,  15'd7664,  15'd9706,  15'd11577,
        15'd13110, 15'd14254, 15'd15176, 15'd15660, 15'd15970, 15'd16163, 15'd16283, 15'd16356,
        15'd16401, 15'd16429, 15'd16445, 15'd16455, 15'd16461, 15'd16465, 15'd16467, 15'd16469,
        15'd16470, 15'd16470, 15'd16470, 15'd16471, 15'd16471, 15'd16471, 15'd16471, 15'd16471
    };

    localparam logic [ROM_WIDTH-1:0] DECEL_ROM [ROM_DEPTH] = '{
        15'd15373, 15'd14736, 15'd13793, 15'd12477, 15'd10781, 15'd8807,  15'd6765,  15'd4894,
        15'd3361,  15'd2217,  15'd1295,  15'd811,   15'd501,   15'd308,   15'd188,   15'd115,
        15'd70,    15'd42,    15'd26,    15'd16,    15'd9,     15'd6,     15'd3,     15'd2,
        15'd1,     15'd1,     15'd1,     15'd1,     15'd1,     15'd1,     15'd1,     15'd1
    };

endpackage

// ----- sv/sigmoid_s_curve_trajectory_generator_unit.sv -----
`timescale 1ns / 1ps

// S-curve joint setpoint generator, positions in signed Q11.20 radians.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 accel_distance,
// 1 cruise_step) and cfg_data; cfg_ready is always high, write only while idle.
// Input channel in_valid/in_ready carries action and position_in:
// a preset loads the current position and stops any motion, a set-target
// latches start, distance and direction, and each tick then yields one
// setpoint (sigmoid acceleration, cruise, sigmoid deceleration, then the
// exact target with at_target high). Ticks while idle give no result.
// Output channel out_valid/out_ready carries setpoint and at_target.
// The result of an accepted transaction goes to the output register, or to
// the skid register while the output stalls. Throughput: one transaction per
// cycle while in_ready is high; the step is done in one pass of comparators
// and adders between the state registers and the output register.
// A two-entry output stage (output register plus skid register) lets an
// input transaction be taken while a result waits; in_ready drops only when
// both entries hold results the receiver has not taken.
// Reset clears the motion state (idle, position zero), empties the output
// stage and restores the default accel_distance and cruise_step.
module sigmoid_s_curve_trajectory_generator_unit #(
    parameter int PROFILE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [20:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic signed [31:0]  position_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  setpoint,
    output logic                at_target
);

    import scurve_pkg::*;

    localparam int LAST_INDEX_INT = (PROFILE_DEPTH > ROM_DEPTH) ? ROM_DEPTH - 1
                                                               : PROFILE_DEPTH - 1;
    localparam logic [4:0] LAST_INDEX = 5'(LAST_INDEX_INT);

    logic [DIST_WIDTH-1:0] accel_distance_reg;
    logic [DIST_WIDTH-1:0] cruise_step_reg;

    logic signed [31:0] last_position_reg, last_position_next;
    logic signed [31:0] start_position_reg, start_position_next;
    logic signed [31:0] goal_position_reg, goal_position_next;
    logic [31:0]        total_distance_reg, total_distance_next;
    logic [31:0]        traveled_reg, traveled_next;
    phase_t             phase_reg, phase_next;
    logic [4:0]         step_index_reg, step_index_next;
    logic               moving_down_reg, moving_down_next;

    logic               out_valid_reg;
    logic signed [31:0] out_setpoint_reg;
    logic               out_at_target_reg;
    logic               skid_valid_reg;
    logic signed [31:0] skid_setpoint_reg;
    logic               skid_at_target_reg;

    logic               in_accept;
    action_t            act;
    logic               res_valid;
    logic signed [31:0] res_setpoint;
    logic               res_at_target;

    logic               accel_go;
    logic               cruise_go;
    logic               decel_go;
    logic [4:0]         decel_index;
    logic [DIST_WIDTH-1:0] delta;
    logic [32:0]        travel_sum;
    logic [31:0]        travel_sat;
    logic signed [33:0] cruise_limit;
    logic signed [33:0] sp_wide;
    logic signed [31:0] sp_sat;
    logic signed [32:0] target_diff;

    function automatic logic [4:0] advance(input logic [4:0] idx);
        return (idx < LAST_INDEX) ? idx + 5'd1 : LAST_INDEX;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_accept = in_valid && in_ready;
    assign act       = action_t'(action);

    // Phase cascade decisions
    assign cruise_limit = $signed({2'b00, total_distance_reg})
                        - $signed({13'd0, accel_distance_reg});
    assign accel_go  = (phase_reg == PH_ACCEL)
                    && (traveled_reg < {11'd0, accel_distance_reg})
                    && ({traveled_reg, 1'b0} < {1'b0, total_distance_reg});
    assign cruise_go = !accel_go
                    && ((phase_reg == PH_ACCEL) || (phase_reg == PH_CRUISE))
                    && ($signed({2'b00, traveled_reg}) < cruise_limit);
    assign decel_go  = !accel_go && !cruise_go && (phase_reg != PH_IDLE)
                    && (traveled_reg < total_distance_reg);
    assign decel_index = (phase_reg == PH_DECEL) ? step_index_reg : 5'd0;

    always_comb
    begin
        delta = '0;
        if (accel_go)
        begin
            delta = {6'd0, ACCEL_ROM[step_index_reg]};
        end
        else if (cruise_go)
        begin
            delta = (cruise_step_reg == '0) ? DIST_WIDTH'(1) : cruise_step_reg;
        end
        else if (decel_go)
        begin
            delta = {6'd0, DECEL_ROM[decel_index]};
        end
    end

    assign travel_sum = {1'b0, traveled_reg} + {12'd0, delta};
    assign travel_sat = travel_sum[32] ? 32'hFFFF_FFFF : travel_sum[31:0];
    assign sp_wide = moving_down_reg
                   ? {{2{start_position_reg[31]}}, start_position_reg} - $signed({2'b00, travel_sat})
                   : {{2{start_position_reg[31]}}, start_position_reg} + $signed({2'b00, travel_sat});

    always_comb
    begin
        if (sp_wide > 34'sh0_7FFF_FFFF)
        begin
            sp_sat = 32'sh7FFF_FFFF;
        end
        else if (sp_wide < -34'sh0_8000_0000)
        begin
            sp_sat = 32'sh8000_0000;
        end
        else
        begin
            sp_sat = sp_wide[31:0];
        end
    end

    assign target_diff = {position_in[31], position_in}
                       - {last_position_reg[31], last_position_reg};

    // Next state
    always_comb
    begin
        last_position_next  = last_position_reg;
        start_position_next = start_position_reg;
        goal_position_next  = goal_position_reg;
        total_distance_next = total_distance_reg;
        traveled_next       = traveled_reg;
        phase_next          = phase_reg;
        step_index_next     = step_index_reg;
        moving_down_next    = moving_down_reg;
        if (in_accept)
        begin
            unique case (act)
                ACT_TARGET:
                begin
                    start_position_next = last_position_reg;
                    goal_position_next  = position_in;
                    moving_down_next    = target_diff[32];
                    total_distance_next = target_diff[32] ? 32'(-target_diff)
                                                          : target_diff[31:0];
                    traveled_next       = '0;
                    step_index_next     = '0;
                    phase_next          = PH_ACCEL;
                end
                ACT_PRESET:
                begin
                    last_position_next = position_in;
                    phase_next         = PH_IDLE;
                end
                ACT_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        priority if (accel_go)
                        begin
                            step_index_next    = advance(step_index_reg);
                            phase_next         = PH_ACCEL;
                            traveled_next      = travel_sat;
                            last_position_next = sp_sat;
                        end
                        else if (cruise_go)
                        begin
                            phase_next         = PH_CRUISE;
                            traveled_next      = travel_sat;
                            last_position_next = sp_sat;
                        end
                        else if (decel_go)
                        begin
                            step_index_next    = advance(decel_index);
                            phase_next         = PH_DECEL;
                            traveled_next      = travel_sat;
                            last_position_next = sp_sat;
                        end
                        else
                        begin
                            // final tick: land exactly on the goal
                            step_index_next    = decel_index;
                            phase_next         = PH_IDLE;
                            last_position_next = goal_position_reg;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result of the accepted transaction
    always_comb
    begin
        res_valid     = in_accept && (act == ACT_TICK) && (phase_reg != PH_IDLE);
        res_at_target = !(accel_go || cruise_go || decel_go);
        res_setpoint  = res_at_target ? goal_position_reg : sp_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_distance_reg <= ACCEL_DISTANCE_RESET;
            cruise_step_reg    <= CRUISE_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACCEL_DISTANCE: accel_distance_reg <= cfg_data;
                REG_CRUISE_STEP:    cruise_step_reg    <= cfg_data;
                default:            cruise_step_reg    <= cruise_step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_position_reg  <= '0;
            start_position_reg <= '0;
            goal_position_reg  <= '0;
            total_distance_reg <= '0;
            traveled_reg       <= '0;
            phase_reg          <= PH_IDLE;
            step_index_reg     <= '0;
            moving_down_reg    <= 1'b0;
        end
        else
        begin
            last_position_reg  <= last_position_next;
            start_position_reg <= start_position_next;
            goal_position_reg  <= goal_position_next;
            total_distance_reg <= total_distance_next;
            traveled_reg       <= traveled_next;
            phase_reg          <= phase_next;
            step_index_reg     <= step_index_next;
            moving_down_reg    <= moving_down_next;
        end
    end

    // Output register and skid register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            // hold the stalled result, park a new one in the skid stage
            if (res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (res_valid)
            begin
                skid_setpoint_reg  <= res_setpoint;
                skid_at_target_reg <= res_at_target;
            end
        end
        else if (skid_valid_reg)
        begin
            out_setpoint_reg  <= skid_setpoint_reg;
            out_at_target_reg <= skid_at_target_reg;
        end
        else if (res_valid)
        begin
            out_setpoint_reg  <= res_setpoint;
            out_at_target_reg <= res_at_target;
        end
    end

    assign out_valid = out_valid_reg;
    assign setpoint  = out_setpoint_reg;
    assign at_target = out_at_target_reg;

endmodule

// ----- tb/tb_sigmoid_s_curve_trajectory_generator_unit.sv -----
`timescale 1ns / 1ps

module tb_sigmoid_s_curve_trajectory_generator_unit;

    import scurve_pkg::*;

    localparam int PROFILE_DEPTH = 16;
    localparam int ROM_LAST = (PROFILE_DEPTH - 1 > 31) ? 31 : PROFILE_DEPTH - 1;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    localparam longint U32_MAX = 64'sh0000_0000_FFFF_FFFF;
    localparam longint POS_MAX_L = 64'sh0000_0000_7FFF_FFFF;
    localparam longint POS_MIN_L = -64'sh0000_0000_8000_0000;
    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

    // Sigmoid velocity steps per tick, Q11.20 radians
    localparam int unsigned RISE_STEPS [32] = '{
        1098, 1735, 2678, 3994, 5690, 7664, 9706, 11577,
        13110, 14254, 15176, 15660, 15970, 16163, 16283, 16356,
        16401, 16429, 16445, 16455, 16461, 16465, 16467, 16469,
        16470, 16470, 16470, 16471, 16471, 16471, 16471, 16471
    };
    localparam int unsigned FALL_STEPS [32] = '{
        15373, 14736, 13793, 12477, 10781, 8807, 6765, 4894,
        3361, 2217, 1295, 811, 501, 308, 188, 115,
        70, 42, 26, 16, 9, 6, 3, 2,
        1, 1, 1, 1, 1, 1, 1, 1
    };

    typedef struct packed {
        logic signed [31:0] setpoint;
        logic               at_target;
    } setpoint_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [20:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         action;
    logic signed [31:0] position_in;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] setpoint;
    logic               at_target;

    // Trajectory state mirrored from the block
    logic signed [31:0] cur_pos;
    logic signed [31:0] origin_pos;
    logic signed [31:0] goal_pos;
    logic [31:0]        span;
    logic [31:0]        covered;
    phase_t             motion;
    logic [4:0]         rom_idx;
    logic               descending;
    logic [20:0]        accel_dist;
    logic [20:0]        cruise_inc;

    setpoint_t   pending_setpoints [$];
    setpoint_t   oldest;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned pattern_left = 0;
    logic [15:0] ready_pattern = '1;

    sigmoid_s_curve_trajectory_generator_unit #(
        .PROFILE_DEPTH(PROFILE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .position_in(position_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .setpoint(setpoint),
        .at_target(at_target)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the setpoint caused by one accepted transaction, if any
    task automatic advance_profile(input action_t act, input logic signed [31:0] pos);
        longint diff;
        longint t;
        longint d;
        longint step;
        longint sp;
        bit     taken;
        case (act)
            ACT_TARGET:
            begin
                diff = longint'(pos) - longint'(cur_pos);
                origin_pos = cur_pos;
                goal_pos = pos;
                descending = (diff < 0);
                span = 32'((diff < 0) ? -diff : diff);
                covered = '0;
                rom_idx = '0;
                motion = PH_ACCEL;
            end
            ACT_PRESET:
            begin
                cur_pos = pos;
                motion = PH_IDLE;
            end
            ACT_TICK:
            begin
                if (motion != PH_IDLE)
                begin
                    t = longint'(covered);
                    d = longint'(span);
                    step = 0;
                    taken = 1'b0;
                    if (motion == PH_ACCEL)
                    begin
                        if (t < longint'(accel_dist) && 2 * t < d)
                        begin
                            step = RISE_STEPS[rom_idx];
                            if (rom_idx < ROM_LAST)
                                rom_idx++;
                            taken = 1'b1;
                        end
                        else
                            motion = PH_CRUISE;
                    end
                    if (!taken && motion == PH_CRUISE)
                    begin
                        if (t < d - longint'(accel_dist))
                        begin
                            step = (cruise_inc == 0) ? 1 : cruise_inc;
                            taken = 1'b1;
                        end
                        else
                        begin
                            motion = PH_DECEL;
                            rom_idx = '0;
                        end
                    end
                    if (!taken && motion == PH_DECEL && t < d)
                    begin
                        step = FALL_STEPS[rom_idx];
                        if (rom_idx < ROM_LAST)
                            rom_idx++;
                        taken = 1'b1;
                    end
                    if (!taken)
                    begin
                        cur_pos = goal_pos;
                        motion = PH_IDLE;
                        pending_setpoints.push_back('{setpoint: goal_pos, at_target: 1'b1});
                    end
                    else
                    begin
                        t = t + step;
                        if (t > U32_MAX)
                            t = U32_MAX;
                        covered = t[31:0];
                        sp = descending ? longint'(origin_pos) - t : longint'(origin_pos) + t;
                        if (sp > POS_MAX_L)
                            sp = POS_MAX_L;
                        if (sp < POS_MIN_L)
                            sp = POS_MIN_L;
                        cur_pos = sp[31:0];
                        pending_setpoints.push_back('{setpoint: cur_pos, at_target: 1'b0});
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic send_item(input action_t act, input logic signed [31:0] pos);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        action      <= act;
        position_in <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_profile(act, pos);
    endtask

    // Drop valid, wait for every expected transaction, then allow for the pipeline
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_setpoints.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [20:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_ACCEL_DISTANCE: accel_dist = value;
            REG_CRUISE_STEP:    cruise_inc = value;
            default:            ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_motion();
        while (motion != PH_IDLE)
            send_item(ACT_TICK, $urandom());
    endtask

    // Pick a target no further than cap from the current position
    function automatic logic signed [31:0] aim(input int unsigned cap);
        longint reach;
        longint goal;
        case ($urandom_range(0, 9))
            0:       reach = 0;
            1:       reach = $urandom_range(1, (cap < 2000) ? cap : 2000);
            default: reach = $urandom_range(0, cap);
        endcase
        goal = $urandom_range(0, 1) ? longint'(cur_pos) - reach : longint'(cur_pos) + reach;
        if (goal > POS_MAX_L)
            goal = POS_MAX_L;
        if (goal < POS_MIN_L)
            goal = POS_MIN_L;
        return goal[31:0];
    endfunction

    task automatic test_idle_inputs();
        send_item(ACT_TICK, 32'sh0);
        send_item(ACT_NONE, 32'shFFFF_FFFF);
        send_item(ACT_PRESET, POS_MAX);
        send_item(ACT_TICK, POS_MAX);
        send_item(ACT_PRESET, POS_MIN);
        send_item(ACT_TICK, POS_MIN);
        send_item(ACT_NONE, 32'sh0);
    endtask

    task automatic test_zero_distance();
        send_item(ACT_PRESET, 32'sh1234_5678);
        send_item(ACT_TARGET, 32'sh1234_5678);
        send_item(ACT_TICK, 32'sh0);
        send_item(ACT_TICK, 32'sh0);
    endtask

    task automatic test_up_down_motion();
        send_item(ACT_PRESET, 32'sh0);
        send_item(ACT_TARGET, 32'sh0010_0000);
        repeat (5) send_item(ACT_TICK, $urandom());
        send_item(ACT_NONE, $urandom());
        run_motion();
        send_item(ACT_TARGET, -32'sh0008_0000);
        run_motion();
    endtask

    task automatic test_retarget_and_preset();
        send_item(ACT_TARGET, cur_pos + 32'sh0020_0000);
        repeat (20) send_item(ACT_TICK, $urandom());
        // retarget mid-motion, starting from the last setpoint
        send_item(ACT_TARGET, 32'sh0);
        repeat (5) send_item(ACT_TICK, $urandom());
        send_item(ACT_PRESET, 32'sd500000);
        send_item(ACT_TICK, $urandom());
        send_item(ACT_TARGET, 32'sd600000);
        run_motion();
    endtask

    task automatic test_clamped_overshoot();
        send_item(ACT_PRESET, POS_MAX - 32'sd100);
        send_item(ACT_TARGET, POS_MAX);
        run_motion();
        send_item(ACT_PRESET, POS_MIN + 32'sd100);
        send_item(ACT_TARGET, POS_MIN);
        run_motion();
    endtask

    // Long enough acceleration to hold the last profile entry for several ticks,
    // then stop before the slow deceleration tail
    task automatic test_rom_saturation();
        settle();
        write_reg(REG_ACCEL_DISTANCE, 21'd200000);
        send_item(ACT_PRESET, 32'sh0);
        send_item(ACT_TARGET, 32'sd400000);
        repeat (24) send_item(ACT_TICK, $urandom());
        send_item(ACT_PRESET, 32'sh0);
    endtask

    task automatic test_zero_cruise_step();
        settle();
        write_reg(REG_ACCEL_DISTANCE, 21'd0);
        write_reg(REG_CRUISE_STEP, 21'd0);
        send_item(ACT_PRESET, -32'sd5);
        send_item(ACT_TARGET, 32'sd35);
        run_motion();
    endtask

    // Full signed span at the largest cruise step, then reverse toward the bottom
    task automatic test_full_range();
        settle();
        write_reg(REG_CRUISE_STEP, 21'h1F_FFFF);
        send_item(ACT_PRESET, POS_MIN);
        send_item(ACT_TARGET, POS_MAX);
        repeat (40) send_item(ACT_TICK, $urandom());
        send_item(ACT_TARGET, POS_MIN);
        repeat (42) send_item(ACT_TICK, $urandom());
        send_item(ACT_PRESET, 32'sh0);
    endtask

    task automatic test_random_traffic();
        int unsigned cap;
        int unsigned counted;
        int unsigned roll;
        logic [20:0] a_val;
        logic [20:0] c_val;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    a_val = 21'd86937;
                    c_val = 21'd16471;
                end
                1:
                begin
                    a_val = '0;
                    c_val = '1;
                end
                2:
                begin
                    a_val = '1;
                    c_val = '0;
                end
                3:
                begin
                    a_val = 21'd1048576;
                    c_val = 21'd1048576;
                end
                4:
                begin
                    a_val = 21'($urandom_range(0, 110000));
                    c_val = 21'd1;
                end
                default:
                begin
                    a_val = $urandom_range(0, 1) ? 21'($urandom_range(0, 110000))
                                                 : 21'($urandom_range(0, 2097151));
                    c_val = $urandom_range(0, 1) ? 21'($urandom_range(5000, 60000))
                                                 : 21'($urandom_range(0, 2097151));
                end
            endcase
            settle();
            write_reg(REG_ACCEL_DISTANCE, a_val);
            write_reg(REG_CRUISE_STEP, c_val);
            // bound the distance so that the slow deceleration tail stays short
            if (accel_dist > 110000)
                cap = 220000;
            else
                cap = 2 * accel_dist + 60 * ((cruise_inc == 0) ? 1 : cruise_inc);
            counted = 0;
            while (counted < 85)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    send_item(ACT_PRESET, $urandom());
                    counted++;
                end
                else if (roll < 14)
                begin
                    send_item(ACT_PRESET, roll[0] ? POS_MAX - $urandom_range(0, 50000)
                                                  : POS_MIN + $urandom_range(0, 50000));
                    counted++;
                end
                else if (roll < 17)
                    send_item(ACT_NONE, $urandom());
                else if (roll < 20)
                    send_item(ACT_TICK, $urandom());
                send_item(ACT_TARGET, aim(cap));
                counted++;
                while (motion != PH_IDLE)
                begin
                    roll = $urandom_range(0, 199);
                    if (roll == 0)
                        send_item(ACT_NONE, $urandom());
                    else if (roll == 1)
                        send_item(ACT_TARGET, aim(cap));
                    else if (roll == 2)
                        send_item(ACT_PRESET, $urandom());
                    else
                        send_item(ACT_TICK, $urandom());
                    if (roll != 0)
                        counted++;
                end
            end
        end
    endtask

    // Receiver stalls on a rotating mask, reloaded now and then
    always @(negedge clk)
    begin
        if (pattern_left == 0)
        begin
            pattern_left <= $urandom_range(8, 64);
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
        end
        else
        begin
            pattern_left <= pattern_left - 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
        out_ready <= ready_pattern[0];
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_setpoints.size() == 0)
            begin
                $error("unexpected result: setpoint %0d at_target %0b", setpoint, at_target);
                fail_count++;
            end
            else
            begin
                oldest = pending_setpoints.pop_front();
                if (setpoint !== oldest.setpoint)
                begin
                    $error("setpoint: expected %0d, actual %0d", oldest.setpoint, setpoint);
                    fail_count++;
                end
                if (at_target !== oldest.at_target)
                begin
                    $error("at_target: expected %0b, actual %0b", oldest.at_target, at_target);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[sigmoid_s_curve_trajectory_generator_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_ACCEL_DISTANCE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        action      = ACT_TICK;
        position_in = '0;
        out_ready   = 1'b0;
        accel_dist  = 21'd86937;
        cruise_inc  = 21'd16471;
        cur_pos     = '0;
        origin_pos  = '0;
        goal_pos    = '0;
        span        = '0;
        covered     = '0;
        motion      = PH_IDLE;
        rom_idx     = '0;
        descending  = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_inputs();
        test_zero_distance();
        test_up_down_motion();
        test_retarget_and_preset();
        test_clamped_overshoot();
        test_rom_saturation();
        test_zero_cruise_step();
        test_full_range();
        test_random_traffic();

        settle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[sigmoid_s_curve_trajectory_generator_unit] OK");
        else
            $display("[sigmoid_s_curve_trajectory_generator_unit] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/scurve_pkg.sv
sv/sigmoid_s_curve_trajectory_generator_unit.sv
tb/tb_sigmoid_s_curve_trajectory_generator_unit.sv
